// ===== design/vpdm_pkg.sv =====
// Shared types, constants and codes for the video packet deframer and config merger.
package vpdm_pkg;

   // Config store geometry
   localparam int CFG_DEPTH = 256;
   localparam int CFG_ROWS  = (CFG_DEPTH + 7) / 8;
   localparam int ROW_W     = (CFG_ROWS > 1) ? $clog2(CFG_ROWS) : 1;
   localparam int LEN_W     = $clog2(CFG_DEPTH + 1);
   localparam int ADDR_W    = (CFG_DEPTH > 1) ? $clog2(CFG_DEPTH) : 1;

   // Prelude codec identifiers
   localparam logic [31:0] ID_AVC  = 32'h6832_3634;
   localparam logic [31:0] ID_HEVC = 32'h6832_3635;
   localparam logic [31:0] ID_AV1  = 32'h0061_7631;

   localparam logic [1:0] CODEC_AVC  = 2'd0;
   localparam logic [1:0] CODEC_HEVC = 2'd1;
   localparam logic [1:0] CODEC_AV1  = 2'd2;
   localparam logic [1:0] CODEC_NONE = 2'd3;

   localparam logic [1:0] KIND_INFO  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_DATA  = 2'd2;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_CODEC = 2'd1;
   localparam logic [1:0] ERR_TRUNC = 2'd2;

   localparam logic [3:0] HDR_LAST = 4'd11;

   typedef enum logic [2:0] {
      PH_PRELUDE,
      PH_HEADER,
      PH_CONFIG,
      PH_MEDIA,
      PH_HALT,
      PH_REPLAY
   } phase_type;

   // Result payload, first member in the top bits
   typedef struct packed {
      logic [1:0]  error_code;
      logic        end_of_packet;
      logic [3:0]  data_bytes;
      logic [63:0] data_word;
      logic [31:0] packet_length;
      logic        key_frame;
      logic [61:0] timestamp;
      logic [31:0] frame_height;
      logic [31:0] frame_width;
      logic [1:0]  codec;
   } rsp_item_type;

   localparam int RSP_W = $bits(rsp_item_type);

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } cfg_wr_type;

endpackage

// ===== design/vpdm_cfg_ram.sv =====
// Config byte store: byte-lane writes, one 8-byte row read per cycle, registered read data.
module vpdm_cfg_ram
   import vpdm_pkg::*;
(
   input  logic             clock,
   input  cfg_wr_type       wr,
   input  logic [ROW_W-1:0] rd_row,
   output logic [63:0]      rd_word
);

   logic [63:0]      mem [CFG_ROWS];
   logic [63:0]      rd_word_ff;
   logic [ROW_W-1:0] wr_row;
   logic [2:0]       wr_lane;

   assign wr_row  = ROW_W'(wr.addr >> 3);
   assign wr_lane = wr.addr[2:0];

   // first byte of a row lands in bits 63:56
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_row][{3'd7 - wr_lane, 3'b000} +: 8] <= wr.data;
      end
      rd_word_ff <= mem[rd_row];
   end

   assign rd_word = rd_word_ff;

endmodule

// ===== design/video_packet_deframer_merger_core.sv =====
// Top level of the video packet deframer and config merger.
// Takes one stream byte per cycle unless stalled. Prelude and header bytes produce at most
// one result; a media header with stored config emits its start item and then holds the
// input during replay, one 8-byte row per cycle from the config RAM read port while
// the result side is not stalled. A result register decouples the two sides, so a byte is
// taken while the previous result waits unless the result side is stalled. The config
// store has no reset sweep: only bytes written by the current config are read.
module video_packet_deframer_merger_core
   import vpdm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // stream_byte
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // codec, frame_width, frame_height, timestamp, key_frame, packet_length,
   // data_word, data_bytes, end_of_packet, error_code
   output logic [RSP_W-1:0] rsp_tdata,
   output logic [1:0]       rsp_tuser,   // kind
   output logic             rsp_tlast    // last_of_run
);

   phase_type        phase_ff, phase_in;
   logic [3:0]       hcnt_ff, hcnt_in;
   logic [87:0]      hdr_ff, hdr_in;
   logic [31:0]      rem_ff, rem_in;
   logic [LEN_W-1:0] clen_ff, clen_in;
   logic             trunc_ff, trunc_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             ovalid_ff, ovalid_in;
   rsp_item_type     odata_ff, odata_in;
   logic [1:0]       okind_ff, okind_in;
   logic             olast_ff, olast_in;

   logic             out_free;
   logic             acc;
   logic [95:0]      full;
   logic [31:0]      hi;
   logic [63:0]      lo;
   logic [32:0]      sum;
   logic [ROW_W-1:0] last_row;
   logic [LEN_W-1:0] row_rem;
   logic [3:0]       row_nb;
   logic [63:0]      rd_word;
   logic [63:0]      row_word;
   cfg_wr_type       wr;
   rsp_item_type     res;

   vpdm_cfg_ram u_ram (
      .clock  (clock),
      .wr     (wr),
      .rd_row (row_in),
      .rd_word(rd_word)
   );

   assign out_free   = !ovalid_ff || rsp_tready;
   assign req_tready = out_free && (phase_ff != PH_REPLAY);
   assign acc        = req_tvalid && req_tready;

   assign full = {hdr_ff, req_tdata};
   assign hi   = full[95:64];
   assign lo   = full[63:0];
   assign sum  = {1'b0, 32'(clen_ff)} + {1'b0, lo[31:0]};

   assign last_row = ROW_W'((clen_ff - LEN_W'(1)) >> 3);
   assign row_rem  = clen_ff - (LEN_W'(row_ff) << 3);
   assign row_nb   = (row_rem >= LEN_W'(8)) ? 4'd8 : 4'(row_rem);

   // bytes past the stored length in the final row are zero
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         row_word[63 - 8 * k -: 8] = (4'(k) < row_nb) ? rd_word[63 - 8 * k -: 8] : 8'h00;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      hcnt_in   = hcnt_ff;
      hdr_in    = hdr_ff;
      rem_in    = rem_ff;
      clen_in   = clen_ff;
      trunc_in  = trunc_ff;
      row_in    = '0;
      ovalid_in = ovalid_ff && !rsp_tready;
      odata_in  = odata_ff;
      okind_in  = okind_ff;
      olast_in  = olast_ff;
      wr        = '0;
      res       = '0;

      case (phase_ff)
         PH_PRELUDE, PH_HEADER: begin
            if (acc) begin
               hdr_in = full[87:0];
               if (hcnt_ff == HDR_LAST) begin
                  hcnt_in = '0;
                  if (phase_ff == PH_PRELUDE) begin
                     if (hi == ID_AVC) begin
                        res.codec = CODEC_AVC;
                     end else if (hi == ID_HEVC) begin
                        res.codec = CODEC_HEVC;
                     end else if (hi == ID_AV1) begin
                        res.codec = CODEC_AV1;
                     end else begin
                        res.codec = CODEC_NONE;
                     end
                     res.frame_width  = lo[63:32];
                     res.frame_height = lo[31:0];
                     if (res.codec == CODEC_NONE) begin
                        res.error_code = ERR_CODEC;
                        phase_in       = PH_HALT;
                     end else begin
                        phase_in = PH_HEADER;
                     end
                     ovalid_in = 1'b1;
                     odata_in  = res;
                     okind_in  = KIND_INFO;
                     olast_in  = 1'b1;
                  end else if (lo[31:0] != 32'd0) begin
                     rem_in = lo[31:0];
                     if (hi[31]) begin
                        clen_in  = '0;
                        trunc_in = 1'b0;
                        phase_in = PH_CONFIG;
                     end else begin
                        res.timestamp     = {hi[29:0], lo[63:32]};
                        res.key_frame     = hi[30];
                        res.packet_length = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                        res.error_code    = trunc_ff ? ERR_TRUNC : ERR_NONE;
                        ovalid_in = 1'b1;
                        odata_in  = res;
                        okind_in  = KIND_START;
                        trunc_in  = 1'b0;
                        if (clen_ff == '0) begin
                           olast_in = 1'b1;
                           phase_in = PH_MEDIA;
                        end else begin
                           olast_in = 1'b0;
                           phase_in = PH_REPLAY;
                        end
                     end
                  end
               end else begin
                  hcnt_in = hcnt_ff + 4'd1;
               end
            end
         end
         PH_CONFIG: begin
            if (acc) begin
               if (clen_ff < LEN_W'(CFG_DEPTH)) begin
                  wr.en   = 1'b1;
                  wr.addr = ADDR_W'(clen_ff);
                  wr.data = req_tdata;
                  clen_in = clen_ff + LEN_W'(1);
               end else begin
                  trunc_in = 1'b1;
               end
               rem_in = rem_ff - 32'd1;
               if (rem_ff == 32'd1) begin
                  phase_in = PH_HEADER;
               end
            end
         end
         PH_MEDIA: begin
            if (acc) begin
               res.data_word     = {req_tdata, 56'd0};
               res.data_bytes    = 4'd1;
               res.end_of_packet = (rem_ff == 32'd1);
               ovalid_in = 1'b1;
               odata_in  = res;
               okind_in  = KIND_DATA;
               olast_in  = 1'b1;
               rem_in    = rem_ff - 32'd1;
               if (rem_ff == 32'd1) begin
                  phase_in = PH_HEADER;
               end
            end
         end
         PH_REPLAY: begin
            // RAM read address runs one row ahead, so rd_word always holds row_ff
            row_in = row_ff;
            if (out_free) begin
               res.data_word  = row_word;
               res.data_bytes = row_nb;
               ovalid_in = 1'b1;
               odata_in  = res;
               okind_in  = KIND_DATA;
               if (row_ff == last_row) begin
                  olast_in = 1'b1;
                  clen_in  = '0;
                  trunc_in = 1'b0;
                  phase_in = PH_MEDIA;
                  row_in   = '0;
               end else begin
                  olast_in = 1'b0;
                  row_in   = row_ff + ROW_W'(1);
               end
            end
         end
         PH_HALT: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_PRELUDE;
         hcnt_ff   <= '0;
         hdr_ff    <= '0;
         rem_ff    <= '0;
         clen_ff   <= '0;
         trunc_ff  <= 1'b0;
         row_ff    <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         hcnt_ff   <= hcnt_in;
         hdr_ff    <= hdr_in;
         rem_ff    <= rem_in;
         clen_ff   <= clen_in;
         trunc_ff  <= trunc_in;
         row_ff    <= row_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      odata_ff <= odata_in;
      okind_ff <= okind_in;
      olast_ff <= olast_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tuser  = okind_ff;
   assign rsp_tlast  = olast_ff;

endmodule

// ===== design/vpdm_checker.sv =====
// Port-level checks for the deframer core, bound to the top level.
module vpdm_checker
   import vpdm_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [7:0]       req_tdata,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata,
   input logic [1:0]       rsp_tuser,
   input logic             rsp_tlast
);

   rsp_item_type r;
   assign r = rsp_tdata;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
                                    && $stable(rsp_tlast))
      else $error("result item changed while stalled");

   a_data_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_DATA |-> r.data_bytes != 4'd0 && r.data_bytes <= 4'd8)
      else $error("data item with bad byte count");

   a_nondata_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_DATA |-> r.data_bytes == 4'd0 && !r.end_of_packet)
      else $error("non-data item carries data fields");

   a_eop_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && r.end_of_packet |-> rsp_tlast && r.data_bytes == 4'd1)
      else $error("end of packet not on a single-byte last item");

   a_codec_err: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_INFO |-> (r.codec == CODEC_NONE) == (r.error_code == ERR_CODEC))
      else $error("codec error flag mismatch");

endmodule

bind video_packet_deframer_merger_core vpdm_checker u_vpdm_checker (.*);

// ===== tb/tb_video_packet_deframer_merger_core.sv =====
// Self-checking testbench for the video packet deframer and config merger core.
module tb_video_packet_deframer_merger_core;
   import vpdm_pkg::*;

   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 64;
   localparam int MODE_SPAN = 300;

   typedef struct {
      logic [1:0]   kind;
      rsp_item_type body;
      logic         last;
   } deframed_result_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata = 8'd0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic [1:0]       rsp_tuser;
   logic             rsp_tlast;

   video_packet_deframer_merger_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   logic [7:0]          stream_bytes[$];
   deframed_result_type expected_results[$];
   logic                req_taken = 1'b0;
   logic                draining = 1'b0;
   int unsigned         cycle_cnt = 0;
   int unsigned         stall_cycles = 0;
   int unsigned         mismatch_count = 0;

   // Predictor state
   phase_type           frame_phase = PH_PRELUDE;
   int unsigned         hdr_cnt = 0;
   logic [95:0]         hdr_bits = '0;
   logic [31:0]         payload_left = '0;
   logic [7:0]          cfg_mem [CFG_DEPTH];
   int unsigned         cfg_len = 0;
   logic                cfg_trunc = 1'b0;
   deframed_result_type held_result;
   logic                have_held = 1'b0;

   function automatic deframed_result_type blank_result(logic [1:0] kind);
      deframed_result_type r;
      r.kind = kind;
      r.body = '0;
      r.last = 1'b0;
      return r;
   endfunction

   // Results of one byte are held back one step so the final one gets its last flag
   function automatic void emit_result(deframed_result_type r);
      if (have_held) expected_results.push_back(held_result);
      held_result = r;
      have_held = 1'b1;
   endfunction

   function automatic void deframe_byte(logic [7:0] b);
      deframed_result_type r;
      logic [63:0] flags;
      logic [31:0] size;
      logic [32:0] total;
      logic [63:0] w;
      int unsigned pos;
      int unsigned k;
      case (frame_phase)
         PH_PRELUDE, PH_HEADER: begin
            hdr_bits = {hdr_bits[87:0], b};
            hdr_cnt++;
            if (hdr_cnt == 12) begin
               hdr_cnt = 0;
               if (frame_phase == PH_PRELUDE) begin
                  r = blank_result(KIND_INFO);
                  case (hdr_bits[95:64])
                     ID_AVC:  r.body.codec = CODEC_AVC;
                     ID_HEVC: r.body.codec = CODEC_HEVC;
                     ID_AV1:  r.body.codec = CODEC_AV1;
                     default: r.body.codec = CODEC_NONE;
                  endcase
                  r.body.frame_width = hdr_bits[63:32];
                  r.body.frame_height = hdr_bits[31:0];
                  if (r.body.codec == CODEC_NONE) begin
                     r.body.error_code = ERR_CODEC;
                     frame_phase = PH_HALT;
                  end else begin
                     frame_phase = PH_HEADER;
                  end
                  emit_result(r);
               end else begin
                  flags = hdr_bits[95:32];
                  size = hdr_bits[31:0];
                  if (size != 0) begin
                     payload_left = size;
                     if (flags[63]) begin
                        cfg_len = 0;
                        cfg_trunc = 1'b0;
                        frame_phase = PH_CONFIG;
                     end else begin
                        r = blank_result(KIND_START);
                        total = 33'(cfg_len) + {1'b0, size};
                        r.body.timestamp = flags[61:0];
                        r.body.key_frame = flags[62];
                        r.body.packet_length = total[32] ? 32'hFFFF_FFFF : total[31:0];
                        r.body.error_code = cfg_trunc ? ERR_TRUNC : ERR_NONE;
                        emit_result(r);
                        pos = 0;
                        while (pos < cfg_len) begin
                           w = '0;
                           k = 0;
                           while (k < 8 && pos < cfg_len) begin
                              w[63 - 8 * k -: 8] = cfg_mem[pos];
                              k++;
                              pos++;
                           end
                           r = blank_result(KIND_DATA);
                           r.body.data_word = w;
                           r.body.data_bytes = 4'(k);
                           emit_result(r);
                        end
                        cfg_len = 0;
                        cfg_trunc = 1'b0;
                        frame_phase = PH_MEDIA;
                     end
                  end
               end
            end
         end
         PH_CONFIG: begin
            if (cfg_len < CFG_DEPTH) begin
               cfg_mem[cfg_len] = b;
               cfg_len++;
            end else begin
               cfg_trunc = 1'b1;
            end
            payload_left--;
            if (payload_left == 0) frame_phase = PH_HEADER;
         end
         PH_MEDIA: begin
            r = blank_result(KIND_DATA);
            r.body.data_word = {b, 56'd0};
            r.body.data_bytes = 4'd1;
            payload_left--;
            if (payload_left == 0) begin
               r.body.end_of_packet = 1'b1;
               frame_phase = PH_HEADER;
            end
            emit_result(r);
         end
         default: ;
      endcase
      if (have_held) begin
         held_result.last = 1'b1;
         expected_results.push_back(held_result);
         have_held = 1'b0;
      end
   endfunction

   task automatic check_result();
      deframed_result_type got;
      deframed_result_type want;
      got.kind = rsp_tuser;
      got.body = rsp_item_type'(rsp_tdata);
      got.last = rsp_tlast;
      if (expected_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10) $display("unexpected result item: %p", got);
      end else begin
         want = expected_results.pop_front();
         if (got.kind !== want.kind || got.body !== want.body || got.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("result mismatch\n  expected %p\n  actual   %p", want, got);
         end
      end
   endtask

   // Idle phases: none, sender 75%, receiver 75%, both 12%
   function automatic logic hold_sender();
      int unsigned mode;
      mode = (cycle_cnt / MODE_SPAN) % 4;
      if (mode == 1) return $urandom_range(0, 99) < 75;
      if (mode == 3) return $urandom_range(0, 99) < 12;
      return 1'b0;
   endfunction

   function automatic logic hold_receiver();
      int unsigned mode;
      mode = (cycle_cnt / MODE_SPAN) % 4;
      if (mode == 2) return $urandom_range(0, 99) < 75;
      if (mode == 3) return $urandom_range(0, 99) < 12;
      return 1'b0;
   endfunction

   always @(negedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_taken) begin
            if (stream_bytes.size() > 0 && !hold_sender()) begin
               req_tdata <= stream_bytes.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= draining || !hold_receiver();
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         stall_cycles <= 0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) deframe_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) check_result();
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stall_cycles <= 0;
         end else if (stream_bytes.size() > 0 || req_tvalid || expected_results.size() > 0) begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
               $display("[video_packet_deframer_merger_core] ERROR");
               $finish;
            end
         end
      end
   end

   // Big-endian byte order, as on the link
   task automatic push_word(logic [63:0] v, int nbytes);
      for (int i = nbytes - 1; i >= 0; i--) stream_bytes.push_back(v[8 * i +: 8]);
   endtask

   task automatic push_header(logic [63:0] flags, logic [31:0] size);
      push_word(flags, 8);
      push_word({32'd0, size}, 4);
   endtask

   task automatic queue_packet(logic [63:0] flags, logic [31:0] size);
      push_header(flags, size);
      for (int i = 0; i < size; i++) stream_bytes.push_back(8'($urandom));
   endtask

   function automatic logic [63:0] rand_flags(logic is_cfg, logic key);
      return {is_cfg, key, 30'($urandom), $urandom};
   endfunction

   initial begin
      int unsigned pick;
      int unsigned sel;
      int unsigned start_cnt;
      logic [31:0] prelude_id;
      logic        big_done;
      pick = $urandom_range(0, 9);
      sel = $urandom_range(0, 2);
      big_done = 1'b0;
      if (pick == 0) begin
         prelude_id = $urandom;
         while (prelude_id == ID_AVC || prelude_id == ID_HEVC || prelude_id == ID_AV1)
            prelude_id = $urandom;
      end else begin
         prelude_id = (sel == 0) ? ID_AVC : (sel == 1) ? ID_HEVC : ID_AV1;
      end
      // Prelude with extreme dimensions
      push_word({32'd0, prelude_id}, 4);
      push_word({32'hFFFF_FFFF, 32'd0}, 8);
      if (pick == 0) begin
         // Halted: everything after the prelude is dropped
         for (int i = 0; i < 48; i++) stream_bytes.push_back(8'($urandom));
      end else begin
         // Config with key flag set (ignored), zero-size header, media merging the config
         queue_packet({2'b11, 62'h3FFF_FFFF_FFFF_FFFF}, 32'd3);
         push_header({2'b01, 62'd0}, 32'd0);
         queue_packet({2'b01, 62'h3FFF_FFFF_FFFF_FFFF}, 32'd1);
         start_cnt = stream_bytes.size();
         while (stream_bytes.size() < start_cnt + 100) begin
            if (!big_done && stream_bytes.size() > start_cnt + 30) begin
               // Overflowed store: full replay of every row plus the truncation flag
               queue_packet(rand_flags(1'b1, 1'($urandom)),
                            32'(CFG_DEPTH + $urandom_range(1, 5)));
               queue_packet(rand_flags(1'b0, 1'($urandom)), 32'($urandom_range(1, 4)));
               big_done = 1'b1;
            end
            sel = $urandom_range(0, 99);
            if (sel < 25)
               queue_packet(rand_flags(1'b1, 1'($urandom)), 32'($urandom_range(1, 20)));
            else if (sel < 80)
               queue_packet(rand_flags(1'b0, 1'($urandom)), 32'($urandom_range(1, 12)));
            else if (sel < 90)
               push_header({$urandom, $urandom}, 32'd0);
            else
               queue_packet({$urandom, $urandom}, 32'($urandom_range(1, 6)));
         end
         // Length saturation: the packet never completes
         queue_packet(rand_flags(1'b1, 1'b0), 32'd5);
         push_header(rand_flags(1'b0, 1'($urandom)), 32'hFFFF_FFFF);
         for (int i = 0; i < 10; i++) stream_bytes.push_back(8'($urandom));
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (stream_bytes.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      draining <= 1'b1;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("[video_packet_deframer_merger_core] OK");
      end else begin
         $display("[video_packet_deframer_merger_core] ERROR");
      end
      $finish;
   end

endmodule
